/* sv/vr3d_pkg.sv */
`timescale 1ns / 1ps
package vr3d_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int FOLD_STEPS   = 4;
    localparam int AW = 34;  // angle residual, Q28
    localparam int XW = 34;  // CORDIC x/y, Q30
    localparam int MW = 36;  // matrix entry, Q26
    localparam int PW = 68;  // wide products and sums
    localparam int LATENCY = CORDIC_STEPS + 8;

    localparam logic signed [AW-1:0] ANG_PI      = 34'sd843314857;
    localparam logic signed [AW-1:0] ANG_HALF_PI = 34'sd421657428;
    localparam logic signed [XW-1:0] CORDIC_K    = 34'sd652032874;
    localparam logic signed [MW-1:0] ONE_Q26     = 36'sd67108864;

    localparam logic signed [31:0] ATAN_Q28 [24] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422, 32'sd8385879, 32'sd4193963, 32'sd2097109,
        32'sd1048571, 32'sd524287, 32'sd262144, 32'sd131072,
        32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192, 32'sd4096,
        32'sd2048, 32'sd1024, 32'sd512, 32'sd256, 32'sd128, 32'sd64, 32'sd32
    };

    localparam logic [1:0] CMD_ROT_X = 2'd0;
    localparam logic [1:0] CMD_ROT_Y = 2'd1;
    localparam logic [1:0] CMD_ROT_Z = 2'd2;
    localparam logic [1:0] CMD_AXIS  = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] angle;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               overflow;
    } t_out;

    typedef struct packed {
        logic                 vld;
        logic                 flip;
        logic signed [AW-1:0] a;
        t_in                  item;
    } t_fold;

    typedef struct packed {
        logic                 vld;
        logic signed [XW-1:0] cos30;
        logic signed [XW-1:0] sin30;
        t_in                  item;
    } t_sc;

    typedef logic [2:0][2:0][MW-1:0] t_mat;

    typedef struct packed {
        logic vld;
        t_mat m;
        t_in  item;
    } t_mx;

endpackage

/* sv/vector_rotate_3d_unit.sv */
`timescale 1ns / 1ps
// Channel   Ports                      Direction  Transfer
// command   start, busy, i_item        in         start high while busy low
// result    o_valid, o_result          out        one result per item, no backpressure
//
// One item enters per clock; busy is always low. Each result passes
// through one fold stage, one stage per CORDIC iteration, a sign stage,
// three matrix stages and three multiply/sum/saturate stages.
// Reset clears only the valid bits of the pipe; data registers are not reset.
// The receiver cannot stall, so the pipe never holds an item back.
module vector_rotate_3d_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  vr3d_pkg::t_in   i_item,
    output logic            o_valid,
    output vr3d_pkg::t_out  o_result
);
    import vr3d_pkg::*;

    t_fold fold;
    t_sc   sc;
    t_mx   mx;

    // The pipe takes a new item every cycle.
    assign busy = 1'b0;

    // Angle folding into the CORDIC convergence range.
    vr3d_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_item  (i_item),
        .o_fold  (fold)
    );

    // Sine and cosine in Q30, one iteration per stage.
    vr3d_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fold  (fold),
        .o_sc    (sc)
    );

    // Rotation matrix in Q26, either axis-aligned or Rodrigues.
    vr3d_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sc    (sc),
        .o_mx    (mx)
    );

    // Matrix times vector, rounding to Q16.16 and saturation.
    vr3d_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mx    (mx),
        .o_vld   (o_valid),
        .o_res   (o_result)
    );

    // Every accepted item gives a result after exactly the pipe latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_valid)
        else $error("item did not produce a result after the pipe latency");

    // No result appears without an item that caused it.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##LATENCY !o_valid)
        else $error("result without a matching item");

    // The overflow flag is set only when some component sits at a rail.
    a_ovf_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.overflow) |->
        (o_result.out_x == 32'sh7FFF_FFFF || o_result.out_x == 32'sh8000_0000 ||
         o_result.out_y == 32'sh7FFF_FFFF || o_result.out_y == 32'sh8000_0000 ||
         o_result.out_z == 32'sh7FFF_FFFF || o_result.out_z == 32'sh8000_0000))
        else $error("overflow flagged with no saturated component");

endmodule

/* sv/vr3d_fold.sv */
`timescale 1ns / 1ps
module vr3d_fold (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  vr3d_pkg::t_in  i_item,
    output vr3d_pkg::t_fold o_fold
);
    import vr3d_pkg::*;

    logic signed [AW-1:0] n_a;
    logic                 n_flip;
    t_fold                r_fold;

    // Bring the angle into [-pi/2, pi/2]; each half turn flips sin and cos.
    always_comb begin
        n_a    = $signed({{2{i_item.angle[15]}}, i_item.angle, 16'h0000});
        n_flip = 1'b0;
        for (int i = 0; i < FOLD_STEPS; i++) begin
            if (n_a > ANG_HALF_PI) begin
                n_a    = n_a - ANG_PI;
                n_flip = ~n_flip;
            end else if (n_a < -ANG_HALF_PI) begin
                n_a    = n_a + ANG_PI;
                n_flip = ~n_flip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold.vld <= 1'b0;
        end else begin
            r_fold.vld <= i_vld;
        end
        r_fold.a    <= n_a;
        r_fold.flip <= n_flip;
        r_fold.item <= i_item;
    end

    assign o_fold = r_fold;
endmodule

/* sv/vr3d_cordic.sv */
`timescale 1ns / 1ps
module vr3d_cordic (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  vr3d_pkg::t_fold i_fold,
    output vr3d_pkg::t_sc   o_sc
);
    import vr3d_pkg::*;

    logic                 r_vld  [1:CORDIC_STEPS];
    logic                 r_flip [1:CORDIC_STEPS];
    logic signed [XW-1:0] r_x    [1:CORDIC_STEPS];
    logic signed [XW-1:0] r_y    [1:CORDIC_STEPS];
    logic signed [AW-1:0] r_a    [1:CORDIC_STEPS];
    t_in                  r_item [1:CORDIC_STEPS];
    t_sc                  r_sc;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        logic                 src_v;
        logic                 src_f;
        logic signed [XW-1:0] src_x;
        logic signed [XW-1:0] src_y;
        logic signed [AW-1:0] src_a;
        t_in                  src_item;

        if (i == 0) begin : g_first
            assign src_v    = i_fold.vld;
            assign src_f    = i_fold.flip;
            assign src_x    = CORDIC_K;
            assign src_y    = '0;
            assign src_a    = i_fold.a;
            assign src_item = i_fold.item;
        end else begin : g_next
            assign src_v    = r_vld[i];
            assign src_f    = r_flip[i];
            assign src_x    = r_x[i];
            assign src_y    = r_y[i];
            assign src_a    = r_a[i];
            assign src_item = r_item[i];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= src_v;
            end
            r_flip[i+1] <= src_f;
            r_item[i+1] <= src_item;
            if (src_a >= 0) begin
                r_x[i+1] <= src_x - (src_y >>> i);
                r_y[i+1] <= src_y + (src_x >>> i);
                r_a[i+1] <= src_a - AW'(ATAN_Q28[i]);
            end else begin
                r_x[i+1] <= src_x + (src_y >>> i);
                r_y[i+1] <= src_y - (src_x >>> i);
                r_a[i+1] <= src_a + AW'(ATAN_Q28[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc.vld <= 1'b0;
        end else begin
            r_sc.vld <= r_vld[CORDIC_STEPS];
        end
        r_sc.cos30 <= r_flip[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
        r_sc.sin30 <= r_flip[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
        r_sc.item  <= r_item[CORDIC_STEPS];
    end

    assign o_sc = r_sc;
endmodule

/* sv/vr3d_matrix.sv */
`timescale 1ns / 1ps
module vr3d_matrix (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vr3d_pkg::t_sc i_sc,
    output vr3d_pkg::t_mx o_mx
);
    import vr3d_pkg::*;

    // Stage 1: rounded sin/cos, k = 1 - cos, axis products.
    logic                 r1_vld;
    logic signed [MW-1:0] r1_c, r1_s;
    logic signed [XW:0]   r1_k;
    logic signed [XW-1:0] r1_cos30;
    logic signed [31:0]   r1_pxx, r1_pxy, r1_pxz, r1_pyy, r1_pyz, r1_pzz;
    logic signed [49:0]   r1_sx, r1_sy, r1_sz;
    t_in                  r1_item;
    // Stage 2: k times axis products.
    logic                 r2_vld;
    logic signed [MW-1:0] r2_c, r2_s;
    logic signed [XW-1:0] r2_cos30;
    logic signed [PW-1:0] r2_kxx, r2_kxy, r2_kxz, r2_kyy, r2_kyz, r2_kzz;
    logic signed [49:0]   r2_sx, r2_sy, r2_sz;
    t_in                  r2_item;
    // Stage 3: matrix.
    t_mx                  r3_mx;

    logic signed [XW-1:0] n_c30, n_s30;
    logic signed [PW-1:0] c58, sx58, sy58, sz58;
    t_mat                 n_m;

    function automatic logic [MW-1:0] q58_to_q26(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        t = (v + (PW'(1) <<< 31)) >>> 32;
        return t[MW-1:0];
    endfunction

    assign n_c30 = (i_sc.cos30 + XW'(8)) >>> 4;
    assign n_s30 = (i_sc.sin30 + XW'(8)) >>> 4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_mx.vld <= 1'b0;
        end else begin
            r1_vld <= i_sc.vld;
            r2_vld <= r1_vld;
            r3_mx.vld <= r2_vld;
        end
        r1_c     <= MW'(n_c30);
        r1_s     <= MW'(n_s30);
        r1_k     <= (XW+1)'(1 <<< 30) - (XW+1)'(i_sc.cos30);
        r1_cos30 <= i_sc.cos30;
        r1_pxx   <= i_sc.item.axis_x * i_sc.item.axis_x;
        r1_pxy   <= i_sc.item.axis_x * i_sc.item.axis_y;
        r1_pxz   <= i_sc.item.axis_x * i_sc.item.axis_z;
        r1_pyy   <= i_sc.item.axis_y * i_sc.item.axis_y;
        r1_pyz   <= i_sc.item.axis_y * i_sc.item.axis_z;
        r1_pzz   <= i_sc.item.axis_z * i_sc.item.axis_z;
        r1_sx    <= i_sc.sin30 * i_sc.item.axis_x;
        r1_sy    <= i_sc.sin30 * i_sc.item.axis_y;
        r1_sz    <= i_sc.sin30 * i_sc.item.axis_z;
        r1_item  <= i_sc.item;

        r2_c     <= r1_c;
        r2_s     <= r1_s;
        r2_cos30 <= r1_cos30;
        r2_kxx   <= r1_k * r1_pxx;
        r2_kxy   <= r1_k * r1_pxy;
        r2_kxz   <= r1_k * r1_pxz;
        r2_kyy   <= r1_k * r1_pyy;
        r2_kyz   <= r1_k * r1_pyz;
        r2_kzz   <= r1_k * r1_pzz;
        r2_sx    <= r1_sx;
        r2_sy    <= r1_sy;
        r2_sz    <= r1_sz;
        r2_item  <= r1_item;

        r3_mx.m    <= n_m;
        r3_mx.item <= r2_item;
    end

    assign c58  = PW'(r2_cos30) <<< 28;
    assign sx58 = PW'(r2_sx) <<< 14;
    assign sy58 = PW'(r2_sy) <<< 14;
    assign sz58 = PW'(r2_sz) <<< 14;

    always_comb begin
        n_m = '0;
        case (r2_item.cmd)
            CMD_ROT_X: begin
                n_m[0][0] = ONE_Q26;
                n_m[1][1] = r2_c;
                n_m[1][2] = -r2_s;
                n_m[2][1] = r2_s;
                n_m[2][2] = r2_c;
            end
            CMD_ROT_Y: begin
                n_m[0][0] = r2_c;
                n_m[0][2] = r2_s;
                n_m[1][1] = ONE_Q26;
                n_m[2][0] = -r2_s;
                n_m[2][2] = r2_c;
            end
            CMD_ROT_Z: begin
                n_m[0][0] = r2_c;
                n_m[0][1] = -r2_s;
                n_m[1][0] = r2_s;
                n_m[1][1] = r2_c;
                n_m[2][2] = ONE_Q26;
            end
            default: begin
                n_m[0][0] = q58_to_q26(c58 + r2_kxx);
                n_m[0][1] = q58_to_q26(r2_kxy - sz58);
                n_m[0][2] = q58_to_q26(r2_kxz + sy58);
                n_m[1][0] = q58_to_q26(r2_kxy + sz58);
                n_m[1][1] = q58_to_q26(c58 + r2_kyy);
                n_m[1][2] = q58_to_q26(r2_kyz - sx58);
                n_m[2][0] = q58_to_q26(r2_kxz - sy58);
                n_m[2][1] = q58_to_q26(r2_kyz + sx58);
                n_m[2][2] = q58_to_q26(c58 + r2_kzz);
            end
        endcase
    end

    assign o_mx = r3_mx;
endmodule

/* sv/vr3d_mac.sv */
`timescale 1ns / 1ps
module vr3d_mac (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vr3d_pkg::t_mx i_mx,
    output logic          o_vld,
    output vr3d_pkg::t_out o_res
);
    import vr3d_pkg::*;

    localparam int SW = PW + 2;
    localparam int RW = SW - 26;

    logic                 r1_vld, r2_vld, r3_vld;
    logic signed [PW-1:0] r1_p [3][3];
    logic signed [RW-1:0] r2_r [3];
    t_out                 r3_res;
    logic signed [31:0]   vec [3];
    logic signed [SW-1:0] n_sum [3];
    logic signed [31:0]   n_sat [3];
    logic [2:0]           n_ovf;

    assign vec[0] = i_mx.item.vec_x;
    assign vec[1] = i_mx.item.vec_y;
    assign vec[2] = i_mx.item.vec_z;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_sum[r] = SW'(r1_p[r][0]) + SW'(r1_p[r][1]) + SW'(r1_p[r][2])
                       + (SW'(1) <<< 25);
            n_ovf[r] = 1'b1;
            if (r2_r[r] > RW'(32'sh7FFF_FFFF)) begin
                n_sat[r] = 32'sh7FFF_FFFF;
            end else if (r2_r[r] < -(RW'(1) <<< 31)) begin
                n_sat[r] = 32'sh8000_0000;
            end else begin
                n_sat[r] = r2_r[r][31:0];
                n_ovf[r] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= i_mx.vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
        for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
                r1_p[r][j] <= $signed(i_mx.m[r][j]) * vec[j];
            end
            r2_r[r] <= RW'(n_sum[r] >>> 26);
        end
        r3_res.out_x    <= n_sat[0];
        r3_res.out_y    <= n_sat[1];
        r3_res.out_z    <= n_sat[2];
        r3_res.overflow <= |n_ovf;
    end

    assign o_vld = r3_vld;
    assign o_res = r3_res;
endmodule

/* tb/tb_vector_rotate_3d_unit.sv */
`timescale 1ns / 1ps
module tb_vector_rotate_3d_unit;
    import vr3d_pkg::*;

    localparam int FLUSH_CYCLES = LATENCY + 20;

    // The atan table of the CORDIC, in Q28 radians.
    localparam longint ATAN_TAB [24] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32
    };
    localparam longint PI_Q28      = 843314857;
    localparam longint HALF_PI_Q28 = 421657428;
    localparam longint GAIN_Q30    = 652032874;
    localparam longint UNIT_Q26    = 64'sd1 << 26;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_in   i_item;
    logic  o_valid;
    t_out  o_result;

    t_out  rotated_q[$];
    int    n_mismatch;
    bit    no_gaps;

    vector_rotate_3d_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Floor division by a power of two. A plain arithmetic shift of a
    // signed 64-bit value already rounds toward minus infinity.
    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_sh(longint v, int s);
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    // Sine and cosine in Q30 of an angle in Q28. The angle is folded into
    // the range of plus or minus pi/2 first, and each fold by pi flips the
    // sign of both results.
    function automatic void cordic_sin_cos(input longint ang, output longint s30,
                                           output longint c30);
        longint a, x, y, dx, dy;
        bit flip;
        a = ang;
        x = GAIN_Q30;
        y = 0;
        flip = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (a > HALF_PI_Q28) begin
                a -= PI_Q28;
                flip = ~flip;
            end else if (a < -HALF_PI_Q28) begin
                a += PI_Q28;
                flip = ~flip;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (a >= 0) begin
                x -= dx;
                y += dy;
                a -= ATAN_TAB[i];
            end else begin
                x += dx;
                y -= dy;
                a += ATAN_TAB[i];
            end
        end
        c30 = flip ? -x : x;
        s30 = flip ? -y : y;
    endfunction

    // Works out the rotated vector for one command item.
    function automatic t_out rotate_vector(t_in it);
        longint s30, c30, s, c, k, c58, sx, sy, sz, kxy, kxz, kyz, ax, ay, az;
        longint acc, res;
        longint m [3][3];
        longint v [3];
        t_out r;
        cordic_sin_cos(longint'(it.angle) * 65536, s30, c30);
        s = round_sh(s30, 4);
        c = round_sh(c30, 4);
        v[0] = it.vec_x;
        v[1] = it.vec_y;
        v[2] = it.vec_z;
        ax = it.axis_x;
        ay = it.axis_y;
        az = it.axis_z;
        foreach (m[i, j]) m[i][j] = 0;
        case (it.cmd)
            CMD_ROT_X: begin
                m[0][0] = UNIT_Q26;
                m[1][1] = c; m[1][2] = -s;
                m[2][1] = s; m[2][2] = c;
            end
            CMD_ROT_Y: begin
                m[0][0] = c;  m[0][2] = s;
                m[1][1] = UNIT_Q26;
                m[2][0] = -s; m[2][2] = c;
            end
            CMD_ROT_Z: begin
                m[0][0] = c; m[0][1] = -s;
                m[1][0] = s; m[1][1] = c;
                m[2][2] = UNIT_Q26;
            end
            default: begin
                // Rodrigues matrix formed exactly in Q58, then rounded to Q26.
                k   = (64'sd1 << 30) - c30;
                c58 = c30 * (64'sd1 << 28);
                sx  = s30 * ax * 16384;
                sy  = s30 * ay * 16384;
                sz  = s30 * az * 16384;
                kxy = k * (ax * ay);
                kxz = k * (ax * az);
                kyz = k * (ay * az);
                m[0][0] = round_sh(c58 + k * (ax * ax), 32);
                m[0][1] = round_sh(kxy - sz, 32);
                m[0][2] = round_sh(kxz + sy, 32);
                m[1][0] = round_sh(kxy + sz, 32);
                m[1][1] = round_sh(c58 + k * (ay * ay), 32);
                m[1][2] = round_sh(kyz - sx, 32);
                m[2][0] = round_sh(kxz - sy, 32);
                m[2][1] = round_sh(kyz + sx, 32);
                m[2][2] = round_sh(c58 + k * (az * az), 32);
            end
        endcase
        r.overflow = 1'b0;
        for (int row = 0; row < 3; row++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += m[row][j] * v[j];
            res = round_sh(acc, 26);
            if (res > 64'sd2147483647) begin
                res = 64'sd2147483647;
                r.overflow = 1'b1;
            end else if (res < -64'sd2147483648) begin
                res = -64'sd2147483648;
                r.overflow = 1'b1;
            end
            case (row)
                0: r.out_x = res[31:0];
                1: r.out_y = res[31:0];
                default: r.out_z = res[31:0];
            endcase
        end
        return r;
    endfunction

    // Sends one item, with a random idle burst before it unless gaps are off.
    // start stays high from one item to the next when there is no gap.
    task automatic send_item(t_in it);
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        rotated_q.push_back(rotate_vector(it));
    endtask

    // Ends a burst of items by lowering start.
    task automatic go_idle();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // Every result is compared with the oldest waiting expectation.
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_valid) begin
            if (rotated_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result %h", o_result);
            end else begin
                exp_r = rotated_q.pop_front();
                if (o_result.out_x !== exp_r.out_x || o_result.out_y !== exp_r.out_y ||
                    o_result.out_z !== exp_r.out_z ||
                    o_result.overflow !== exp_r.overflow) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("expected x=%h y=%h z=%h ovf=%b got x=%h y=%h z=%h ovf=%b",
                                 exp_r.out_x, exp_r.out_y, exp_r.out_z, exp_r.overflow,
                                 o_result.out_x, o_result.out_y, o_result.out_z,
                                 o_result.overflow);
                end
            end
        end
    end

    function automatic t_in rand_item(bit unit_axis);
        t_in it;
        int pick;
        it.cmd    = 2'($urandom_range(0, 3));
        it.angle  = 16'($urandom);
        pick      = $urandom_range(0, 3);
        // Mostly moderate vectors, so that overflow stays the exception.
        it.vec_x  = (pick == 0) ? 32'($urandom) : 32'($signed(20'($urandom)));
        it.vec_y  = (pick == 0) ? 32'($urandom) : 32'($signed(20'($urandom)));
        it.vec_z  = (pick == 0) ? 32'($urandom) : 32'($signed(24'($urandom)));
        it.axis_x = 16'($urandom);
        it.axis_y = 16'($urandom);
        it.axis_z = 16'($urandom);
        if (unit_axis) begin
            // A coordinate axis or a diagonal, both close to unit length.
            case ($urandom_range(0, 3))
                0: begin it.axis_x = 16'sd16384; it.axis_y = 0; it.axis_z = 0; end
                1: begin it.axis_x = 0; it.axis_y = -16'sd16384; it.axis_z = 0; end
                2: begin it.axis_x = 0; it.axis_y = 0; it.axis_z = 16'sd16384; end
                default: begin
                    it.axis_x = $urandom_range(0, 1) ? 16'sd9459 : -16'sd9459;
                    it.axis_y = $urandom_range(0, 1) ? 16'sd9459 : -16'sd9459;
                    it.axis_z = $urandom_range(0, 1) ? 16'sd9459 : -16'sd9459;
                end
            endcase
        end
        return it;
    endfunction

    // Every mode at small and extreme angles, X and Z rotations also at zero, with extreme vectors.
    task automatic test_directed();
        t_in it;
        int angs [6] = '{0, 6434, -6434, 12868, 32767, -32768};
        for (int cm = 0; cm < 4; cm++) begin
            for (int a = 0; a < 5; a++) begin
                it = '0;
                it.cmd = 2'(cm);
                it.angle = 16'(angs[a + (cm & 1)]);
                it.vec_x = 32'sd65536;
                it.vec_y = -32'sd131072;
                it.vec_z = 32'sd196608;
                it.axis_x = 16'sd16384;
                if (a == 4) begin
                    it.vec_x = 32'h7FFF_FFFF;
                    it.vec_y = 32'h8000_0000;
                    it.vec_z = 32'h7FFF_FFFF;
                end
                send_item(it);
            end
        end
        // Axis far from unit length, at both extremes of the axis fields.
        it = '0;
        it.cmd = CMD_AXIS;
        it.angle = 16'sd100;
        it.vec_x = 32'h4000_0000;
        it.vec_y = 32'hC000_0000;
        it.vec_z = 32'h7FFF_FFFF;
        it.axis_x = 16'sh7FFF;
        it.axis_y = 16'sh8000;
        it.axis_z = 16'sh7FFF;
        send_item(it);
        it.axis_x = 16'sh8000;
        it.axis_z = 16'sh8000;
        send_item(it);
        go_idle();
    endtask

    task automatic test_random(int n, bit gaps_off);
        no_gaps = gaps_off;
        for (int i = 0; i < n; i++) send_item(rand_item($urandom_range(0, 2) != 0));
        go_idle();
    endtask

    initial begin
        n_mismatch = 0;
        no_gaps = 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1200, 1'b0);
        // Last stretch at full rate with no idling.
        test_random(400, 1'b1);
        while (rotated_q.size() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0 && rotated_q.size() == 0)
            $display("vector_rotate_3d_unit: match");
        else
            $display("vector_rotate_3d_unit: mismatch");
        $finish;
    end

    initial begin
        #2000000;
        $display("vector_rotate_3d_unit: mismatch");
        $finish;
    end

endmodule
